// ===== rtl/owr_pkg.sv =====
// ----------------------------------------------------------------------------
// owr_pkg: shared types and constants of the 1-Wire temperature reader
// Sequence steps, configuration record, result record and command bytes.
// ----------------------------------------------------------------------------
package owr_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 21;
   localparam int unsigned TICK_W      = 21;
   localparam int unsigned STAGE_W     = 4;

   localparam logic [TICK_W-1:0] READ_REST_TICKS = TICK_W'(45);

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_RECOVER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_START    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_HOLD    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_RECOVER  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_SAMPLE   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONV_WAIT     = 3'd7;

   // Sequence stages
   localparam logic [STAGE_W-1:0] STG_RESET_A   = 4'd0;
   localparam logic [STAGE_W-1:0] STG_SKIP_A    = 4'd1;
   localparam logic [STAGE_W-1:0] STG_CONVERT   = 4'd2;
   localparam logic [STAGE_W-1:0] STG_CONV_WAIT = 4'd3;
   localparam logic [STAGE_W-1:0] STG_RESET_B   = 4'd4;
   localparam logic [STAGE_W-1:0] STG_SKIP_B    = 4'd5;
   localparam logic [STAGE_W-1:0] STG_READ_PAD  = 4'd6;
   localparam logic [STAGE_W-1:0] STG_READ_LOW  = 4'd7;
   localparam logic [STAGE_W-1:0] STG_READ_HIGH = 4'd8;

   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   typedef enum logic [3:0] {
      STEP_IDLE       = 4'd0,
      STEP_RST_LOW    = 4'd1,
      STEP_RST_HIGH   = 4'd2,
      STEP_RST_SAMPLE = 4'd3,
      STEP_RST_REC    = 4'd4,
      STEP_W_LOW      = 4'd5,
      STEP_W_HOLD     = 4'd6,
      STEP_W_REC      = 4'd7,
      STEP_R_LOW      = 4'd8,
      STEP_R_HIGH     = 4'd9,
      STEP_R_SAMPLE   = 4'd10,
      STEP_R_REST     = 4'd11,
      STEP_R_REC      = 4'd12,
      STEP_CONV       = 4'd13,
      STEP_DONE       = 4'd14
   } step_type;

   typedef struct packed {
      logic [9:0]  reset_low_ticks;
      logic [7:0]  presence_wait_ticks;
      logic [9:0]  reset_recovery_ticks;
      logic [5:0]  slot_start_ticks;
      logic [7:0]  write_hold_ticks;
      logic [5:0]  slot_recovery_ticks;
      logic [5:0]  read_sample_ticks;
      logic [20:0] conversion_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic        drive_enable;
      logic        drive_level;
      logic        busy_res;
      logic        presence_fail;
      logic        done_res;
      logic [15:0] temperature;
   } rsp_type;

   // Command byte sent in each write stage
   function automatic logic [7:0] stage_cmd(input logic [STAGE_W-1:0] stage);
      logic [7:0] cmd;
      case (stage)
         STG_SKIP_A, STG_SKIP_B: cmd = CMD_SKIP_ROM;
         STG_CONVERT:            cmd = CMD_CONVERT;
         STG_READ_PAD:           cmd = CMD_READ_PAD;
         default:                cmd = 8'h00;
      endcase
      return cmd;
   endfunction

endpackage

// ===== rtl/owr_req_if.sv =====
// ----------------------------------------------------------------------------
// owr_req_if: tick channel into the reader
// Valid/ready handshake carrying the start request and sampled line level.
// ----------------------------------------------------------------------------
interface owr_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic line_level;

   modport source (output valid, output start_req, output line_level, input ready);
   modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

// ===== rtl/owr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// owr_rsp_if: result channel out of the reader
// Valid/ready handshake carrying the line drive and status of one tick.
// ----------------------------------------------------------------------------
interface owr_rsp_if;
   logic        valid;
   logic        ready;
   logic        drive_enable;
   logic        drive_level;
   logic        busy_res;
   logic        presence_fail;
   logic        done_res;
   logic [15:0] temperature;

   modport source (output valid, output drive_enable, output drive_level, output busy_res,
                   output presence_fail, output done_res, output temperature, input ready);
   modport sink   (input valid, input drive_enable, input drive_level, input busy_res,
                   input presence_fail, input done_res, input temperature, output ready);
endinterface

// ===== rtl/one_wire_temperature_reader.sv =====
// ----------------------------------------------------------------------------
// one_wire_temperature_reader: 1-Wire master for one temperature read
// Each result item is registered and appears in the cycle after its tick item is accepted.
// Throughput: one tick item per cycle unless a waiting result is held back, set by the single sequencer state update.
// The result register lets a new tick in while the previous result is taken.
// Reset (synchronous, active high) returns the sequencer to idle, clears the
// result register and loads the default timing registers.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader (
   input  logic                             clock,
   input  logic                             reset,
   owr_req_if.sink                          req_chan,
   owr_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [owr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [owr_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   // Each item on the request channel is one tick of the bus waveform. The
   // sequencer advances on every accepted item and produces exactly one
   // result item, which describes how the line is driven during that tick.

   owr_pkg::cfg_type  cfg;
   owr_pkg::rsp_type  tick_rsp;
   logic              rsp_space;
   logic              tick_fire;

   // A tick is taken whenever the result register is empty or is being
   // emptied in the same cycle.
   assign req_chan.ready = rsp_space;
   assign tick_fire      = req_chan.valid && rsp_space;

   owr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // The sequencer works out the line drive and status of the tick and
   // its next state in one pass of combinational logic.
   owr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .tick_fire  (tick_fire),
      .start_req  (req_chan.start_req),
      .line_level (req_chan.line_level),
      .cfg        (cfg),
      .rsp        (tick_rsp)
   );

   owr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (tick_fire),
      .load_data (tick_rsp),
      .space     (rsp_space),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== rtl/owr_csr.sv =====
// ----------------------------------------------------------------------------
// owr_csr: timing registers
// Holds the eight tick counts written through the plain write port.
// ----------------------------------------------------------------------------
module owr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [owr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [owr_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output owr_pkg::cfg_type                 cfg
);

   owr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            owr_pkg::CSR_RESET_LOW:     cfg_in.reset_low_ticks       = csr_write_data[9:0];
            owr_pkg::CSR_PRESENCE_WAIT: cfg_in.presence_wait_ticks   = csr_write_data[7:0];
            owr_pkg::CSR_RESET_RECOVER: cfg_in.reset_recovery_ticks  = csr_write_data[9:0];
            owr_pkg::CSR_SLOT_START:    cfg_in.slot_start_ticks      = csr_write_data[5:0];
            owr_pkg::CSR_WRITE_HOLD:    cfg_in.write_hold_ticks      = csr_write_data[7:0];
            owr_pkg::CSR_SLOT_RECOVER:  cfg_in.slot_recovery_ticks   = csr_write_data[5:0];
            owr_pkg::CSR_READ_SAMPLE:   cfg_in.read_sample_ticks     = csr_write_data[5:0];
            owr_pkg::CSR_CONV_WAIT:     cfg_in.conversion_wait_ticks = csr_write_data[20:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= 10'd500;
         cfg_ff.presence_wait_ticks   <= 8'd55;
         cfg_ff.reset_recovery_ticks  <= 10'd400;
         cfg_ff.slot_start_ticks      <= 6'd6;
         cfg_ff.write_hold_ticks      <= 8'd50;
         cfg_ff.slot_recovery_ticks   <= 6'd10;
         cfg_ff.read_sample_ticks     <= 6'd8;
         cfg_ff.conversion_wait_ticks <= 21'd1200000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/owr_seq.sv =====
// ----------------------------------------------------------------------------
// owr_seq: bus sequencer
// Steps through reset, write and read slots one tick per accepted item.
// ----------------------------------------------------------------------------
module owr_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              tick_fire,
   input  logic              start_req,
   input  logic              line_level,
   input  owr_pkg::cfg_type  cfg,
   output owr_pkg::rsp_type  rsp
);

   owr_pkg::step_type                step_ff, step_in;
   logic [owr_pkg::TICK_W-1:0]       tick_ff, tick_in;
   logic [2:0]                       bit_ff, bit_in;
   logic [7:0]                       shift_ff, shift_in;
   logic [7:0]                       low_ff, low_in;
   logic [15:0]                      temp_ff, temp_in;
   logic [owr_pkg::STAGE_W-1:0]      stage_ff, stage_in;
   logic                             pfail_ff, pfail_in;

   logic [owr_pkg::TICK_W-1:0]       dur, limit;
   logic                             en, lvl, busy, pf, done;
   logic                             enter;
   logic [owr_pkg::STAGE_W-1:0]      enter_stage;

   always_comb begin
      step_in     = step_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      low_in      = low_ff;
      temp_in     = temp_ff;
      stage_in    = stage_ff;
      pfail_in    = pfail_ff;
      en          = 1'b0;
      lvl         = 1'b0;
      busy        = 1'b1;
      pf          = 1'b0;
      done        = 1'b0;
      dur         = owr_pkg::TICK_W'(1);
      enter       = 1'b0;
      enter_stage = stage_ff + owr_pkg::STAGE_W'(1);

      // Line drive and phase length of the current step
      case (step_ff)
         owr_pkg::STEP_RST_LOW: begin
            en = 1'b1; dur = owr_pkg::TICK_W'(cfg.reset_low_ticks);
         end
         owr_pkg::STEP_RST_HIGH: begin
            en = 1'b1; lvl = 1'b1; dur = owr_pkg::TICK_W'(cfg.presence_wait_ticks);
         end
         owr_pkg::STEP_RST_SAMPLE: begin
            pfail_in = line_level;
            pf       = line_level;
         end
         owr_pkg::STEP_RST_REC: begin
            en = 1'b1; lvl = 1'b1; dur = owr_pkg::TICK_W'(cfg.reset_recovery_ticks);
         end
         owr_pkg::STEP_W_LOW: begin
            en = 1'b1; dur = owr_pkg::TICK_W'(cfg.slot_start_ticks);
         end
         owr_pkg::STEP_W_HOLD: begin
            en = 1'b1; lvl = shift_ff[0]; dur = owr_pkg::TICK_W'(cfg.write_hold_ticks);
         end
         owr_pkg::STEP_W_REC: begin
            en = 1'b1; lvl = 1'b1; dur = owr_pkg::TICK_W'(cfg.slot_recovery_ticks);
         end
         owr_pkg::STEP_R_LOW: begin
            en = 1'b1; dur = owr_pkg::TICK_W'(cfg.slot_start_ticks);
         end
         owr_pkg::STEP_R_HIGH: begin
            en = 1'b1; lvl = 1'b1; dur = owr_pkg::TICK_W'(cfg.read_sample_ticks);
         end
         owr_pkg::STEP_R_SAMPLE: begin
            shift_in = {line_level, shift_ff[7:1]};
         end
         owr_pkg::STEP_R_REST: begin
            dur = owr_pkg::READ_REST_TICKS;
         end
         owr_pkg::STEP_R_REC: begin
            en = 1'b1; lvl = 1'b1; dur = owr_pkg::TICK_W'(cfg.slot_recovery_ticks);
         end
         owr_pkg::STEP_CONV: begin
            en = 1'b1; lvl = 1'b1; dur = cfg.conversion_wait_ticks;
         end
         owr_pkg::STEP_DONE: begin
            busy = 1'b0; done = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase

      // A zero length is taken as one tick
      limit = (dur == '0) ? owr_pkg::TICK_W'(1) : dur;

      if (step_ff == owr_pkg::STEP_DONE) begin
         stage_in = owr_pkg::STG_RESET_A;
         step_in  = owr_pkg::STEP_IDLE;
         tick_in  = '0;
      end else if (step_ff == owr_pkg::STEP_IDLE) begin
         tick_in = '0;
         if (start_req) begin
            pfail_in    = 1'b0;
            enter       = 1'b1;
            enter_stage = owr_pkg::STG_RESET_A;
         end
      end else begin
         tick_in = tick_ff + owr_pkg::TICK_W'(1);
         if (tick_in >= limit) begin
            tick_in = '0;
            case (step_ff)
               owr_pkg::STEP_RST_LOW:    step_in = owr_pkg::STEP_RST_HIGH;
               owr_pkg::STEP_RST_HIGH:   step_in = owr_pkg::STEP_RST_SAMPLE;
               owr_pkg::STEP_RST_SAMPLE: step_in = owr_pkg::STEP_RST_REC;
               owr_pkg::STEP_RST_REC: begin
                  // No answer from the sensor: run the reset pulse again
                  if (pfail_ff) step_in = owr_pkg::STEP_RST_LOW;
                  else          enter   = 1'b1;
               end
               owr_pkg::STEP_W_LOW: step_in = owr_pkg::STEP_W_HOLD;
               owr_pkg::STEP_W_HOLD: begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  step_in  = owr_pkg::STEP_W_REC;
               end
               owr_pkg::STEP_W_REC: begin
                  if (bit_ff == 3'd7) begin
                     enter = 1'b1;
                  end else begin
                     bit_in  = bit_ff + 3'd1;
                     step_in = owr_pkg::STEP_W_LOW;
                  end
               end
               owr_pkg::STEP_R_LOW:    step_in = owr_pkg::STEP_R_HIGH;
               owr_pkg::STEP_R_HIGH:   step_in = owr_pkg::STEP_R_SAMPLE;
               owr_pkg::STEP_R_SAMPLE: step_in = owr_pkg::STEP_R_REST;
               owr_pkg::STEP_R_REST:   step_in = owr_pkg::STEP_R_REC;
               owr_pkg::STEP_R_REC: begin
                  if (bit_ff != 3'd7) begin
                     bit_in  = bit_ff + 3'd1;
                     step_in = owr_pkg::STEP_R_LOW;
                  end else if (stage_ff == owr_pkg::STG_READ_LOW) begin
                     low_in      = shift_ff;
                     enter       = 1'b1;
                     enter_stage = owr_pkg::STG_READ_HIGH;
                  end else begin
                     temp_in = {shift_ff, low_ff};
                     bit_in  = 3'd0;
                     step_in = owr_pkg::STEP_DONE;
                  end
               end
               owr_pkg::STEP_CONV: begin
                  enter       = 1'b1;
                  enter_stage = owr_pkg::STG_RESET_B;
               end
               default: begin
                  stage_in = owr_pkg::STG_RESET_A;
                  step_in  = owr_pkg::STEP_IDLE;
               end
            endcase
         end
      end

      // Opening of a new stage of the sequence
      if (enter) begin
         stage_in = enter_stage;
         bit_in   = 3'd0;
         tick_in  = '0;
         case (enter_stage)
            owr_pkg::STG_RESET_A, owr_pkg::STG_RESET_B: begin
               step_in = owr_pkg::STEP_RST_LOW;
            end
            owr_pkg::STG_SKIP_A, owr_pkg::STG_CONVERT,
            owr_pkg::STG_SKIP_B, owr_pkg::STG_READ_PAD: begin
               shift_in = owr_pkg::stage_cmd(enter_stage);
               step_in  = owr_pkg::STEP_W_LOW;
            end
            owr_pkg::STG_CONV_WAIT: begin
               step_in = owr_pkg::STEP_CONV;
            end
            owr_pkg::STG_READ_LOW, owr_pkg::STG_READ_HIGH: begin
               shift_in = 8'h00;
               step_in  = owr_pkg::STEP_R_LOW;
            end
            default: begin
               stage_in = owr_pkg::STG_RESET_A;
               step_in  = owr_pkg::STEP_IDLE;
            end
         endcase
      end

      rsp.drive_enable  = en;
      rsp.drive_level   = en & lvl;
      rsp.busy_res      = busy;
      rsp.presence_fail = pf;
      rsp.done_res      = done;
      rsp.temperature   = temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= owr_pkg::STEP_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         low_ff   <= '0;
         temp_ff  <= '0;
         stage_ff <= owr_pkg::STG_RESET_A;
         pfail_ff <= 1'b0;
      end else if (tick_fire) begin
         step_ff  <= step_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         low_ff   <= low_in;
         temp_ff  <= temp_in;
         stage_ff <= stage_in;
         pfail_ff <= pfail_in;
      end
   end

endmodule

// ===== rtl/owr_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// owr_rsp_reg: result register
// Holds one result item until the sink takes it; frees itself on the same edge.
// ----------------------------------------------------------------------------
module owr_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  owr_pkg::rsp_type  load_data,
   output logic              space,
   owr_rsp_if.source         rsp_chan
);

   logic              valid_ff, valid_in;
   owr_pkg::rsp_type  data_ff;

   assign space    = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.drive_enable  = data_ff.drive_enable;
   assign rsp_chan.drive_level   = data_ff.drive_level;
   assign rsp_chan.busy_res      = data_ff.busy_res;
   assign rsp_chan.presence_fail = data_ff.presence_fail;
   assign rsp_chan.done_res      = data_ff.done_res;
   assign rsp_chan.temperature   = data_ff.temperature;

endmodule

// ===== rtl/owr_checker.sv =====
// ----------------------------------------------------------------------------
// owr_checker: port checks of the 1-Wire temperature reader
// Watches the handshakes and status outputs seen at the top level.
// ----------------------------------------------------------------------------
module owr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        drive_enable,
   input logic        drive_level,
   input logic        busy_res,
   input logic        presence_fail,
   input logic        done_res,
   input logic [15:0] temperature
);

   // A tick offered while no result is waiting is always taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("tick refused while no result is waiting");

   // A result that is held back keeps its temperature.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(temperature))
      else $error("waiting result changed or vanished");

   // A released line always reads as level low.
   a_released_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !drive_enable |-> !drive_level)
      else $error("drive level set with the line released");

   // The done tick is a released, idle tick.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res && !drive_enable && !presence_fail)
      else $error("done shown while busy or driving");

   // A missing presence is only reported on the released sample tick.
   a_pf_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && presence_fail |-> busy_res && !drive_enable)
      else $error("presence failure outside the sample tick");

endmodule

bind one_wire_temperature_reader owr_checker u_owr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .drive_enable  (rsp_chan.drive_enable),
   .drive_level   (rsp_chan.drive_level),
   .busy_res      (rsp_chan.busy_res),
   .presence_fail (rsp_chan.presence_fail),
   .done_res      (rsp_chan.done_res),
   .temperature   (rsp_chan.temperature)
);
